FILE: rtl/ssd_pkg.sv
// Shared types and constants for the signed Q16 slope divider.
`default_nettype none

package ssd_pkg;

    // Number of fraction bits in the result.
    localparam int FRAC_BITS = 16;

    localparam int DIVIDEND_W = 64;
    localparam int DIVISOR_W  = 47;
    localparam int RATE_W     = 64;

    // The numerator magnitude with the fraction bits appended; one cell per bit.
    localparam int NUM_W = DIVIDEND_W + FRAC_BITS;

    // Cycles from an accepted request to its result strobe.
    localparam int LATENCY = NUM_W + 2;

    localparam logic [RATE_W-1:0] RATE_MAX = {1'b0, {(RATE_W-1){1'b1}}};
    localparam logic [RATE_W-1:0] RATE_MIN = {1'b1, {(RATE_W-1){1'b0}}};

    // Contents of one stage of the divider chain.
    typedef struct packed {
        logic                 valid;
        logic                 neg;
        logic [DIVISOR_W-1:0] divisor;
        logic [DIVISOR_W-1:0] rem;
        logic [NUM_W-1:0]     acc;
    } t_stage;

endpackage

`default_nettype wire

FILE: rtl/ssd_cell.sv
// One restoring division step of the divider chain, registered at its output.
`default_nettype none

module ssd_cell (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire ssd_pkg::t_stage i_stage,
    output ssd_pkg::t_stage     o_stage
);

    logic [ssd_pkg::DIVISOR_W:0]   w_trial;
    logic [ssd_pkg::DIVISOR_W:0]   w_diff;
    logic                          w_ge;
    logic [ssd_pkg::DIVISOR_W-1:0] n_rem;
    logic [ssd_pkg::NUM_W-1:0]     n_acc;
    logic                          r_valid;
    logic                          r_neg;
    logic [ssd_pkg::DIVISOR_W-1:0] r_divisor;
    logic [ssd_pkg::DIVISOR_W-1:0] r_rem;
    logic [ssd_pkg::NUM_W-1:0]     r_acc;

    // Bring down the next numerator bit and try to subtract the divisor.
    assign w_trial = {i_stage.rem, i_stage.acc[ssd_pkg::NUM_W-1]};
    assign w_diff  = w_trial - {1'b0, i_stage.divisor};
    assign w_ge    = (w_trial >= {1'b0, i_stage.divisor});
    assign n_rem   = w_ge ? w_diff[ssd_pkg::DIVISOR_W-1:0] : w_trial[ssd_pkg::DIVISOR_W-1:0];
    // The consumed numerator bit leaves at the top; the quotient bit enters at the bottom.
    assign n_acc   = {i_stage.acc[ssd_pkg::NUM_W-2:0], w_ge};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_stage.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg     <= i_stage.neg;
        r_divisor <= i_stage.divisor;
        r_rem     <= n_rem;
        r_acc     <= n_acc;
    end

    assign o_stage.valid   = r_valid;
    assign o_stage.neg     = r_neg;
    assign o_stage.divisor = r_divisor;
    assign o_stage.rem     = r_rem;
    assign o_stage.acc     = r_acc;

    // The partial remainder stays below a nonzero divisor.
    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_stage.valid && (o_stage.divisor != '0)) |-> (o_stage.rem < o_stage.divisor))
        else $error("ssd_cell: remainder not below divisor");

    // A valid request moves on by exactly one stage.
    a_valid_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stage.valid |=> o_stage.valid)
        else $error("ssd_cell: request lost");

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_stage.valid |=> !o_stage.valid)
        else $error("ssd_cell: request invented");

    // The divisor and sign travel with the request unchanged.
    a_divisor_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stage.valid |=> (o_stage.divisor == $past(i_stage.divisor)
                           && o_stage.neg == $past(i_stage.neg)))
        else $error("ssd_cell: divisor or sign changed");

endmodule

`default_nettype wire

FILE: rtl/signed_q16_slope_divider_top.sv
// Top level of the signed fixed-point divider: input stage, cell chain and output stage.
//
//   Channel   Ports                          Handshake
//   request   i_dividend, i_divisor          start high while busy low
//   result    o_rate                         o_rate_valid strobe, one cycle
//
// Every result passes, in order, the sign stage at the input, one register stage per
// quotient bit in the cell chain, and the sign and saturation stage at the output.
// A new request is accepted in every cycle; busy stays low.
// Reset is synchronous and active low; it clears the valid bits of all stages.
// The receiver cannot stall, so no result is ever held back.
`default_nettype none

module signed_q16_slope_divider_top (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 start,
    input  wire logic signed [ssd_pkg::DIVIDEND_W-1:0] i_dividend,
    input  wire logic        [ssd_pkg::DIVISOR_W-1:0]  i_divisor,
    output logic                                      busy,
    output logic                                      o_rate_valid,
    output logic signed      [ssd_pkg::RATE_W-1:0]     o_rate
);

    ssd_pkg::t_stage                    w_chain [0:ssd_pkg::NUM_W];
    ssd_pkg::t_stage                    w_last;
    logic                               w_neg;
    logic [ssd_pkg::DIVIDEND_W-1:0]     w_mag;
    logic                               r_in_valid;
    logic                               r_in_neg;
    logic [ssd_pkg::DIVISOR_W-1:0]      r_in_divisor;
    logic [ssd_pkg::DIVIDEND_W-1:0]     r_in_mag;
    logic                               w_sat;
    logic [ssd_pkg::RATE_W-1:0]         w_q;
    logic [ssd_pkg::RATE_W-1:0]         n_rate;
    logic                               r_rate_valid;
    logic [ssd_pkg::RATE_W-1:0]         r_rate;

    assign busy = 1'b0;

    // Take the magnitude of the dividend; the most negative value maps to 2^63 exactly.
    assign w_neg = i_dividend[ssd_pkg::DIVIDEND_W-1];
    assign w_mag = w_neg ? (ssd_pkg::DIVIDEND_W'(0) - $unsigned(i_dividend))
                         : $unsigned(i_dividend);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in_neg     <= w_neg;
        r_in_divisor <= i_divisor;
        r_in_mag     <= w_mag;
    end

    assign w_chain[0].valid   = r_in_valid;
    assign w_chain[0].neg     = r_in_neg;
    assign w_chain[0].divisor = r_in_divisor;
    assign w_chain[0].rem     = '0;
    assign w_chain[0].acc     = {r_in_mag, {ssd_pkg::FRAC_BITS{1'b0}}};

    for (genvar g = 0; g < ssd_pkg::NUM_W; g++) begin : g_cell
        ssd_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_stage (w_chain[g]),
            .o_stage (w_chain[g+1])
        );
    end

    assign w_last = w_chain[ssd_pkg::NUM_W];

    // The full quotient saturates once it reaches 2^63, that is any bit at 63 or above.
    assign w_sat = |w_last.acc[ssd_pkg::NUM_W-1:ssd_pkg::RATE_W-1];
    assign w_q   = w_last.acc[ssd_pkg::RATE_W-1:0];

    always_comb begin
        priority if (w_last.divisor == '0) begin
            n_rate = '0;
        end else if (w_sat) begin
            n_rate = w_last.neg ? ssd_pkg::RATE_MIN : ssd_pkg::RATE_MAX;
        end else if (w_last.neg) begin
            n_rate = ssd_pkg::RATE_W'(0) - w_q;
        end else begin
            n_rate = w_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate_valid <= 1'b0;
        end else begin
            r_rate_valid <= w_last.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rate <= n_rate;
    end

    assign o_rate_valid = r_rate_valid;
    assign o_rate       = $signed(r_rate);

    // Every accepted request gives its result strobe.
    a_result_on_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##(ssd_pkg::LATENCY) o_rate_valid)
        else $error("signed_q16_slope_divider_top: result missing");

    // A zero divisor gives a zero rate.
    a_zero_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_divisor == '0)) |-> ##(ssd_pkg::LATENCY) (o_rate == '0))
        else $error("signed_q16_slope_divider_top: zero divisor gave nonzero rate");

    // A non-negative dividend never gives a negative rate.
    a_sign_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_dividend[ssd_pkg::DIVIDEND_W-1])
            |-> ##(ssd_pkg::LATENCY) !o_rate[ssd_pkg::RATE_W-1])
        else $error("signed_q16_slope_divider_top: sign of rate flipped");

    // No strobe without a request leaving the chain.
    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_last.valid |=> !o_rate_valid)
        else $error("signed_q16_slope_divider_top: result invented");

endmodule

`default_nettype wire
